// ----- src/i2cm_pkg.sv -----
// Shared types, constants and reset values of the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned UnitW    = 16;
  localparam int unsigned TimeoutW = 10;
  localparam int unsigned CfgW     = 16;

  localparam logic [UnitW-1:0]    UnitTicksRst  = 16'd50;
  localparam logic [TimeoutW-1:0] AckTimeoutRst = 10'd250;
  localparam logic [7:0]          MsbMask       = 8'h80;

  typedef enum logic {
    CFG_UNIT_TICKS  = 1'b0,
    CFG_ACK_TIMEOUT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_STOP_A   = 4'd3,
    PH_STOP_B   = 4'd4,
    PH_WR_SET   = 4'd5,
    PH_WR_HIGH  = 4'd6,
    PH_WR_LOW   = 4'd7,
    PH_ACK_REL  = 4'd8,
    PH_ACK_CLK  = 4'd9,
    PH_ACK_POLL = 4'd10,
    PH_RD_LOW   = 4'd11,
    PH_RD_HIGH  = 4'd12,
    PH_RA_LOW   = 4'd13,
    PH_RA_HIGH  = 4'd14
  } phase_e;

  typedef struct packed {
    logic          cmd_valid;
    action_e       action;
    logic [7:0]    tx_byte;
    logic          send_ack;
    logic          sda_in;
  } item_t;

  typedef struct packed {
    phase_e              phase;
    logic [3:0]          bit_count;
    logic [7:0]          shift_reg;
    logic [UnitW-1:0]    unit_timer;
    logic [2:0]          units_left;
    logic [TimeoutW-1:0] poll_count;
    logic                scl;
    logic                sda;
    logic                drive;
    logic                ack_bit;
    logic [7:0]          rx;
    logic                ack_ok;
    logic                ack_err;
  } state_t;

  typedef struct packed {
    logic       ack_error;
    logic       ack_ok;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } result_t;

  localparam state_t StateRst = '{
    phase:      PH_IDLE,
    bit_count:  4'd0,
    shift_reg:  8'd0,
    unit_timer: '0,
    units_left: 3'd0,
    poll_count: '0,
    scl:        1'b1,
    sda:        1'b1,
    drive:      1'b1,
    ack_bit:    1'b0,
    rx:         8'd0,
    ack_ok:     1'b0,
    ack_err:    1'b0
  };

endpackage

// ----- src/i2cm_step.sv -----
// Next-state logic of the engine for one clock tick.
`timescale 1ns / 1ps

module i2cm_step import i2cm_pkg::*; (
  input  state_t              state_i,
  input  item_t               item_i,
  input  logic [UnitW-1:0]    unit_ticks_i,
  input  logic [TimeoutW-1:0] ack_timeout_i,
  output state_t              state_o,
  output result_t             result_o
);

  function automatic state_t go_to(state_t s, phase_e ph, logic [2:0] units);
    state_t r;
    r            = s;
    r.phase      = ph;
    r.units_left = units;
    r.unit_timer = '0;
    return r;
  endfunction

  logic [UnitW-1:0] ut;
  logic [UnitW:0]   timer_inc;
  logic [2:0]       units_dec;
  logic [3:0]       bits_inc;
  logic [7:0]       shl;
  state_t           nx;
  logic             done;

  assign ut        = (unit_ticks_i == '0) ? {{(UnitW-1){1'b0}}, 1'b1} : unit_ticks_i;
  assign timer_inc = {1'b0, state_i.unit_timer} + {{UnitW{1'b0}}, 1'b1};
  assign units_dec = state_i.units_left - 3'd1;
  assign bits_inc  = state_i.bit_count + 4'd1;
  assign shl       = {state_i.shift_reg[6:0], 1'b0};

  always_comb begin
    nx   = state_i;
    done = 1'b0;
    if (state_i.phase == PH_IDLE) begin
      if (item_i.cmd_valid) begin
        unique case (item_i.action)
          ACT_START: begin
            nx.drive = 1'b1;
            nx.sda   = 1'b1;
            nx.scl   = 1'b1;
            nx       = go_to(nx, PH_START_A, 3'd4);
          end
          ACT_STOP: begin
            nx.drive = 1'b1;
            nx.scl   = 1'b0;
            nx.sda   = 1'b0;
            nx       = go_to(nx, PH_STOP_A, 3'd4);
          end
          ACT_WRITE: begin
            nx.shift_reg = item_i.tx_byte;
            nx.bit_count = 4'd0;
            nx.ack_ok    = 1'b0;
            nx.ack_err   = 1'b0;
            nx.drive     = 1'b1;
            nx.scl       = 1'b0;
            nx.sda       = |(item_i.tx_byte & MsbMask);
            nx           = go_to(nx, PH_WR_SET, 3'd2);
          end
          default: begin
            nx.ack_bit   = item_i.send_ack;
            nx.shift_reg = 8'd0;
            nx.bit_count = 4'd0;
            nx.drive     = 1'b0;
            nx.sda       = 1'b1;
            nx.scl       = 1'b0;
            nx           = go_to(nx, PH_RD_LOW, 3'd2);
          end
        endcase
      end
    end else if (state_i.phase == PH_ACK_POLL) begin
      priority if (!item_i.sda_in) begin
        nx.scl    = 1'b0;
        nx.ack_ok = 1'b1;
        nx        = go_to(nx, PH_IDLE, 3'd0);
        done      = 1'b1;
      end else if (state_i.poll_count >= ack_timeout_i) begin
        // No acknowledge in time: flag it and release the bus with a stop.
        nx.ack_err = 1'b1;
        nx.ack_ok  = 1'b0;
        nx.drive   = 1'b1;
        nx.scl     = 1'b0;
        nx.sda     = 1'b0;
        nx         = go_to(nx, PH_STOP_A, 3'd4);
      end else begin
        nx.poll_count = state_i.poll_count + {{(TimeoutW-1){1'b0}}, 1'b1};
      end
    end else if (timer_inc >= {1'b0, ut}) begin
      nx.unit_timer = '0;
      nx.units_left = units_dec;
      if (units_dec == 3'd0) begin
        unique case (state_i.phase)
          PH_START_A: begin
            nx.sda = 1'b0;
            nx     = go_to(nx, PH_START_B, 3'd4);
          end
          PH_STOP_A: begin
            nx.scl = 1'b1;
            nx.sda = 1'b1;
            nx     = go_to(nx, PH_STOP_B, 3'd4);
          end
          PH_WR_SET: begin
            nx.scl = 1'b1;
            nx     = go_to(nx, PH_WR_HIGH, 3'd2);
          end
          PH_WR_HIGH: begin
            nx.scl = 1'b0;
            nx     = go_to(nx, PH_WR_LOW, 3'd2);
          end
          PH_WR_LOW: begin
            nx.shift_reg = shl;
            nx.bit_count = bits_inc;
            if (bits_inc >= 4'd8) begin
              nx.drive = 1'b0;
              nx.sda   = 1'b1;
              nx       = go_to(nx, PH_ACK_REL, 3'd1);
            end else begin
              nx.sda = |(shl & MsbMask);
              nx     = go_to(nx, PH_WR_SET, 3'd2);
            end
          end
          PH_ACK_REL: begin
            nx.scl = 1'b1;
            nx     = go_to(nx, PH_ACK_CLK, 3'd1);
          end
          PH_ACK_CLK: begin
            nx.poll_count = '0;
            nx            = go_to(nx, PH_ACK_POLL, 3'd0);
          end
          PH_RD_LOW: begin
            nx.scl = 1'b1;
            nx     = go_to(nx, PH_RD_HIGH, 3'd1);
          end
          PH_RD_HIGH: begin
            nx.shift_reg = {state_i.shift_reg[6:0], item_i.sda_in};
            nx.bit_count = bits_inc;
            nx.scl       = 1'b0;
            if (bits_inc >= 4'd8) begin
              nx.drive = 1'b1;
              nx.sda   = ~state_i.ack_bit;
              nx       = go_to(nx, PH_RA_LOW, 3'd2);
            end else begin
              nx = go_to(nx, PH_RD_LOW, 3'd2);
            end
          end
          PH_RA_LOW: begin
            nx.scl = 1'b1;
            nx     = go_to(nx, PH_RA_HIGH, 3'd2);
          end
          PH_START_B, PH_RA_HIGH: begin
            nx.scl = 1'b0;
            if (state_i.phase == PH_RA_HIGH) begin
              nx.rx = state_i.shift_reg;
            end
            nx   = go_to(nx, PH_IDLE, 3'd0);
            done = 1'b1;
          end
          default: begin
            nx   = go_to(nx, PH_IDLE, 3'd0);
            done = 1'b1;
          end
        endcase
      end
    end else begin
      nx.unit_timer = timer_inc[UnitW-1:0];
    end
  end

  assign state_o = nx;

  assign result_o = '{
    ack_error: nx.ack_err,
    ack_ok:    nx.ack_ok,
    rx_byte:   nx.rx,
    done_res:  done,
    busy_res:  (nx.phase != PH_IDLE),
    sda_drive: nx.drive,
    sda_level: nx.sda,
    scl_level: nx.scl
  };

endmodule

// ----- src/i2cm_out_reg.sv -----
// Result register that holds one finished result until the sink takes it.
`timescale 1ns / 1ps

module i2cm_out_reg import i2cm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  input  logic    ready_i,
  output logic    valid_o,
  output logic    free_o,
  output result_t data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: state, configuration and stream ports.
`timescale 1ns / 1ps

// One input transaction is one system clock tick of the I2C engine: it carries
// an optional command and the sampled SDA level, and produces exactly one result
// transaction with the pin levels and status after that tick. A tick is taken
// every cycle while the result register is empty or being read, so the block
// sustains one tick per clock; each result is held in the single result register
// between the state update and the output port.
// Commands presented while busy are ignored. Write configuration only while
// the engine is idle and no result is pending.
module i2c_master_byte_engine import i2cm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
  input  logic [15:0]     s_axis_tdata,
  // [0] cmd_valid, [2:1] action
  input  logic [2:0]      s_axis_tuser,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_ok, [14] ack_error, [15] zero
  output logic [15:0]     m_axis_tdata
);

  logic [UnitW-1:0]    unit_ticks_q;
  logic [TimeoutW-1:0] ack_timeout_q;
  state_t              state_q, state_d;
  item_t               item;
  result_t             result, out_data;
  logic                accept, free;

  assign item = '{
    cmd_valid: s_axis_tuser[0],
    action:    action_e'(s_axis_tuser[2:1]),
    tx_byte:   s_axis_tdata[7:0],
    send_ack:  s_axis_tdata[8],
    sda_in:    s_axis_tdata[9]
  };

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q  <= UnitTicksRst;
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UNIT_TICKS:  unit_ticks_q  <= cfg_data_i[UnitW-1:0];
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  i2cm_step u_step (
    .state_i       (state_q),
    .item_i        (item),
    .unit_ticks_i  (unit_ticks_q),
    .ack_timeout_i (ack_timeout_q),
    .state_o       (state_d),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  i2cm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .data_i  (result),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .free_o  (free),
    .data_o  (out_data)
  );

  assign m_axis_tdata = {1'b0, out_data};

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_data.done_res |-> !out_data.busy_res)
    else $error("done pulse reported while still busy");

  a_ack_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_data.ack_ok && out_data.ack_error))
    else $error("ack_ok and ack_error set together");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  a_idle_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q))
    else $error("engine state changed without a tick");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the I2C master byte engine, one engine tick per transaction.
`timescale 1ns / 1ps

module tb_top;
  import i2cm_pkg::*;

  localparam int AckNever = 2000;

  typedef enum logic [1:0] {
    ROW_IDLE,
    ROW_CMD,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    action_e     act;
    cfg_idx_e    reg_sel;
    logic [15:0] val;
    logic        send_ack;
    logic [7:0]  line;
    int          ack_polls;
    bit          typed;
    result_t     res;
  } plan_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_idx_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata = '0;
  logic [2:0]      s_axis_tuser = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [15:0]     m_axis_tdata;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int fail_cnt = 0;

  // Expected pin and status words, oldest first.
  result_t exp_pins_q[$];
  plan_row_t plan_q[$];

  // Bus model: the byte a slave puts on SDA during a read, and how many high
  // ACK polls it lets pass before pulling SDA low.
  logic [7:0] line_byte = 8'h00;
  int         ack_wait = 0;

  // Engine mirror.
  logic [UnitW-1:0]    unit_ticks_q = UnitTicksRst;
  logic [TimeoutW-1:0] ack_limit_q = AckTimeoutRst;
  phase_e              eng_phase = PH_IDLE;
  logic [3:0]          bit_cnt = '0;
  logic [7:0]          shreg = '0;
  logic [UnitW-1:0]    unit_tmr = '0;
  logic [2:0]          units_q = '0;
  logic [TimeoutW-1:0] polls = '0;
  logic                scl_q = 1'b1;
  logic                sda_q = 1'b1;
  logic                drv_q = 1'b1;
  logic                ack_req = 1'b0;
  logic [7:0]          rx_q = '0;
  logic                ok_q = 1'b0;
  logic                err_q = 1'b0;
  logic                done_q = 1'b0;

  i2c_master_byte_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic result_t pins(logic scl, logic sda, logic drv, logic busy, logic done,
                                   logic [7:0] rx, logic ok, logic err);
    result_t r;
    r.scl_level = scl;
    r.sda_level = sda;
    r.sda_drive = drv;
    r.busy_res  = busy;
    r.done_res  = done;
    r.rx_byte   = rx;
    r.ack_ok    = ok;
    r.ack_error = err;
    return r;
  endfunction

  function automatic void enter_phase(phase_e ph, int unsigned n);
    eng_phase = ph;
    units_q   = n[2:0];
    unit_tmr  = '0;
  endfunction

  function automatic void end_cmd();
    eng_phase = PH_IDLE;
    units_q   = '0;
    unit_tmr  = '0;
    done_q    = 1'b1;
  endfunction

  function automatic void begin_stop();
    drv_q = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    enter_phase(PH_STOP_A, 4);
  endfunction

  // Pin changes when the hold time of the current phase has run out.
  function automatic void leave_phase(logic sda);
    case (eng_phase)
      PH_START_A: begin
        sda_q = 1'b0;
        enter_phase(PH_START_B, 4);
      end
      PH_START_B: begin
        scl_q = 1'b0;
        end_cmd();
      end
      PH_STOP_A: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        enter_phase(PH_STOP_B, 4);
      end
      PH_WR_SET: begin
        scl_q = 1'b1;
        enter_phase(PH_WR_HIGH, 2);
      end
      PH_WR_HIGH: begin
        scl_q = 1'b0;
        enter_phase(PH_WR_LOW, 2);
      end
      PH_WR_LOW: begin
        shreg   = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          drv_q = 1'b0;
          sda_q = 1'b1;
          enter_phase(PH_ACK_REL, 1);
        end else begin
          sda_q = shreg[7];
          enter_phase(PH_WR_SET, 2);
        end
      end
      PH_ACK_REL: begin
        scl_q = 1'b1;
        enter_phase(PH_ACK_CLK, 1);
      end
      PH_ACK_CLK: begin
        polls = '0;
        enter_phase(PH_ACK_POLL, 0);
      end
      PH_RD_LOW: begin
        scl_q = 1'b1;
        enter_phase(PH_RD_HIGH, 1);
      end
      PH_RD_HIGH: begin
        shreg   = {shreg[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
        scl_q   = 1'b0;
        if (bit_cnt >= 4'd8) begin
          drv_q = 1'b1;
          sda_q = ~ack_req;
          enter_phase(PH_RA_LOW, 2);
        end else begin
          enter_phase(PH_RD_LOW, 2);
        end
      end
      PH_RA_LOW: begin
        scl_q = 1'b1;
        enter_phase(PH_RA_HIGH, 2);
      end
      PH_RA_HIGH: begin
        scl_q = 1'b0;
        rx_q  = shreg;
        end_cmd();
      end
      default: end_cmd();
    endcase
  endfunction

  // Advances the engine mirror by one tick and returns the pin and status word.
  function automatic result_t advance_engine(item_t it);
    int unsigned ut;
    ut = (unit_ticks_q == '0) ? 1 : unit_ticks_q;
    done_q = 1'b0;
    if (eng_phase == PH_IDLE) begin
      if (it.cmd_valid) begin
        case (it.action)
          ACT_START: begin
            drv_q = 1'b1;
            sda_q = 1'b1;
            scl_q = 1'b1;
            enter_phase(PH_START_A, 4);
          end
          ACT_STOP: begin_stop();
          ACT_WRITE: begin
            shreg   = it.tx_byte;
            bit_cnt = '0;
            ok_q    = 1'b0;
            err_q   = 1'b0;
            drv_q   = 1'b1;
            scl_q   = 1'b0;
            sda_q   = it.tx_byte[7];
            enter_phase(PH_WR_SET, 2);
          end
          default: begin
            ack_req = it.send_ack;
            shreg   = '0;
            bit_cnt = '0;
            drv_q   = 1'b0;
            sda_q   = 1'b1;
            scl_q   = 1'b0;
            enter_phase(PH_RD_LOW, 2);
          end
        endcase
      end
    end else if (eng_phase == PH_ACK_POLL) begin
      if (!it.sda_in) begin
        scl_q = 1'b0;
        ok_q  = 1'b1;
        end_cmd();
      end else if (polls >= ack_limit_q) begin
        err_q = 1'b1;
        ok_q  = 1'b0;
        begin_stop();
      end else begin
        polls = polls + 1'b1;
      end
    end else begin
      if (32'(unit_tmr) + 1 >= ut) begin
        unit_tmr = '0;
        units_q  = units_q - 3'd1;
        if (units_q == 3'd0) leave_phase(it.sda_in);
      end else begin
        unit_tmr = unit_tmr + 1'b1;
      end
    end
    return pins(scl_q, sda_q, drv_q, eng_phase != PH_IDLE, done_q, rx_q, ok_q, err_q);
  endfunction

  // SDA as the slave drives it in the current phase of the engine.
  function automatic logic line_level();
    if (eng_phase == PH_RD_HIGH) return line_byte[7 - bit_cnt];
    if (eng_phase == PH_ACK_POLL) return (int'(polls) >= ack_wait) ? 1'b0 : 1'b1;
    return 1'($urandom_range(1));
  endfunction

  function automatic int pick_ack_wait();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(3);
    if (r < 90) return $urandom_range(12);
    return AckNever;
  endfunction

  // Random tick: while idle a command comes now and then; while busy stray
  // commands are sent that the engine must ignore.
  function automatic item_t random_tick(bit allow_cmd);
    item_t it;
    it.action   = action_e'($urandom_range(3));
    it.tx_byte  = 8'($urandom);
    it.send_ack = 1'($urandom_range(1));
    if (eng_phase == PH_IDLE) begin
      it.cmd_valid = allow_cmd && ($urandom_range(99) < 40);
      if (it.cmd_valid) begin
        line_byte = 8'($urandom);
        ack_wait  = pick_ack_wait();
      end
    end else begin
      it.cmd_valid = ($urandom_range(3) == 0);
    end
    it.sda_in = line_level();
    return it;
  endfunction

  function automatic void add_row(row_kind_e kind, action_e act, cfg_idx_e sel,
                                  logic [15:0] val, logic ack, logic [7:0] line,
                                  int polls_n, bit typed, result_t res);
    plan_row_t r;
    r.kind      = kind;
    r.act       = act;
    r.reg_sel   = sel;
    r.val       = val;
    r.send_ack  = ack;
    r.line      = line;
    r.ack_polls = polls_n;
    r.typed     = typed;
    r.res       = res;
    plan_q.push_back(r);
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Presents one tick, waits for its transaction and records what it must produce.
  task automatic send_tick(input item_t it, input bit typed, input result_t typed_res);
    result_t pred;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.sda_in, it.send_ack, it.tx_byte};
    s_axis_tuser  <= {it.action, it.cmd_valid};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = advance_engine(it);
    exp_pins_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_reg(input cfg_idx_e sel, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (exp_pins_q.size() != 0);
    repeat (2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_UNIT_TICKS) unit_ticks_q = val;
    else ack_limit_q = val[TimeoutW-1:0];
  endtask

  task automatic run_random(input int budget);
    int n;
    n = 0;
    while (n < budget || eng_phase != PH_IDLE) begin
      send_tick(random_tick(n < budget), 1'b0, '0);
      n++;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[14:0]);
      if (exp_pins_q.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = exp_pins_q.pop_front();
        cmp_field("scl_level", want.scl_level, got.scl_level);
        cmp_field("sda_level", want.sda_level, got.sda_level);
        cmp_field("sda_drive", want.sda_drive, got.sda_drive);
        cmp_field("busy_res", want.busy_res, got.busy_res);
        cmp_field("done_res", want.done_res, got.done_res);
        cmp_field("rx_byte", want.rx_byte, got.rx_byte);
        cmp_field("ack_ok", want.ack_ok, got.ack_ok);
        cmp_field("ack_error", want.ack_error, got.ack_error);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    item_t it;
    // Engine starts at reset timing; typed rows give the expected result of their first tick.
    add_row(ROW_IDLE, ACT_START, CFG_UNIT_TICKS, '0, 1'b0, '0, 0, 1'b1,
            pins(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    add_row(ROW_CMD, ACT_START, CFG_UNIT_TICKS, '0, 1'b0, '0, 0, 1'b1,
            pins(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    // A zero unit length behaves as one tick per unit.
    add_row(ROW_CFG, ACT_START, CFG_UNIT_TICKS, 16'h0000, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_WRITE, CFG_UNIT_TICKS, 16'h00FF, 1'b0, '0, 0, 1'b1,
            pins(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    add_row(ROW_CMD, ACT_WRITE, CFG_UNIT_TICKS, 16'h0000, 1'b0, '0, 5, 1'b1,
            pins(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    add_row(ROW_CMD, ACT_READ, CFG_UNIT_TICKS, '0, 1'b1, 8'hA5, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_READ, CFG_UNIT_TICKS, '0, 1'b0, 8'h5A, 0, 1'b0, '0);
    // Upper data bits beyond the timeout width are dropped, giving a zero timeout.
    add_row(ROW_CFG, ACT_START, CFG_ACK_TIMEOUT, 16'hFC00, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_WRITE, CFG_UNIT_TICKS, 16'h0080, 1'b0, '0, AckNever, 1'b0, '0);
    add_row(ROW_CMD, ACT_WRITE, CFG_UNIT_TICKS, 16'h0001, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_CFG, ACT_START, CFG_ACK_TIMEOUT, 16'hFFFF, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_WRITE, CFG_UNIT_TICKS, 16'h007F, 1'b0, '0, AckNever, 1'b0, '0);
    add_row(ROW_CFG, ACT_START, CFG_ACK_TIMEOUT, 16'h0001, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_WRITE, CFG_UNIT_TICKS, 16'h0055, 1'b0, '0, 1, 1'b0, '0);
    add_row(ROW_CMD, ACT_WRITE, CFG_UNIT_TICKS, 16'h00AA, 1'b0, '0, 2, 1'b0, '0);
    add_row(ROW_CMD, ACT_STOP, CFG_UNIT_TICKS, '0, 1'b0, '0, 0, 1'b0, '0);
    // Longest unit length: only idle ticks run with it.
    add_row(ROW_CFG, ACT_START, CFG_UNIT_TICKS, 16'hFFFF, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_IDLE, ACT_START, CFG_UNIT_TICKS, '0, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_CFG, ACT_START, CFG_UNIT_TICKS, 16'h0002, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_READ, CFG_UNIT_TICKS, '0, 1'b0, 8'hFF, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_READ, CFG_UNIT_TICKS, '0, 1'b1, 8'h00, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_START, CFG_UNIT_TICKS, '0, 1'b0, '0, 0, 1'b0, '0);
    add_row(ROW_CMD, ACT_STOP, CFG_UNIT_TICKS, '0, 1'b0, '0, 0, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        write_reg(plan_q[i].reg_sel, plan_q[i].val);
      end else begin
        it.cmd_valid = (plan_q[i].kind == ROW_CMD);
        it.action    = plan_q[i].act;
        it.tx_byte   = plan_q[i].val[7:0];
        it.send_ack  = plan_q[i].send_ack;
        it.sda_in    = 1'($urandom_range(1));
        line_byte    = plan_q[i].line;
        ack_wait     = plan_q[i].ack_polls;
        send_tick(it, plan_q[i].typed, plan_q[i].res);
        while (eng_phase != PH_IDLE) send_tick(random_tick(1'b0), 1'b0, '0);
      end
    end

    tx_idle_pct = 31;
    rx_idle_pct = 69;
    write_reg(CFG_UNIT_TICKS, 16'h0001);
    write_reg(CFG_ACK_TIMEOUT, 16'h0003);
    run_random(200);

    tx_idle_pct = 69;
    rx_idle_pct = 31;
    write_reg(CFG_UNIT_TICKS, 16'h0002);
    write_reg(CFG_ACK_TIMEOUT, 16'h0005);
    run_random(200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_UNIT_TICKS, 16'h0003);
    write_reg(CFG_ACK_TIMEOUT, 16'h0020);
    run_random(200);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (exp_pins_q.size() != 0);
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0 && exp_pins_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/i2cm_pkg.sv
src/i2cm_step.sv
src/i2cm_out_reg.sv
src/i2c_master_byte_engine.sv
tb/sv/tb_top.sv
